// ===== hdl/accumulator_machine_execute_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that are shared by the execute unit modules.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AME_ASSERT(lbl, prop, msg)
`define AME_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/ame_pkg.sv =====
// ----------------------------------------------------------------------------
// Accumulator machine execute package
// Field widths, opcodes, status codes and the multiply/divide command type.
// ----------------------------------------------------------------------------
package ame_pkg;

  localparam int OPC_W  = 4;
  localparam int ADDR_W = 8;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_MUL    = 4'd3,
    OP_DIV    = 4'd4,
    OP_JMP    = 4'd5,
    OP_JMPN   = 4'd6,
    OP_JMPP   = 4'd7,
    OP_JMPZ   = 4'd8,
    OP_COPY   = 4'd9,
    OP_LOAD   = 4'd10,
    OP_STORE  = 4'd11,
    OP_INPUT  = 4'd12,
    OP_OUTPUT = 4'd13,
    OP_STOP   = 4'd14
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_ILLEGAL  = 2'd2
  } st_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EXEC  = 1'b1;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_cmd_t;

endpackage

// ===== hdl/ame_if.sv =====
// ----------------------------------------------------------------------------
// Accumulator machine execute channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ame_req_if import ame_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [OPC_W-1:0]         opcode;
  logic [ADDR_W-1:0]        addr_a;
  logic [ADDR_W-1:0]        addr_b;
  logic signed [VAL_W-1:0]  in_value;

  modport source (output valid, func, opcode, addr_a, addr_b, in_value, input ready);
  modport sink (input valid, func, opcode, addr_a, addr_b, in_value, output ready);
endinterface

interface ame_rsp_if import ame_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  acc_value;
  logic [ADDR_W-1:0]        next_pc;
  logic                     out_valid;
  logic signed [VAL_W-1:0]  out_value;
  logic                     is_halted;
  logic [ST_W-1:0]          status;

  modport source (output valid, acc_value, next_pc, out_valid, out_value, is_halted, status,
                  input ready);
  modport sink (input valid, acc_value, next_pc, out_valid, out_value, is_halted, status,
                output ready);
endinterface

// ===== hdl/accumulator_machine_execute_top.sv =====
// ----------------------------------------------------------------------------
// Accumulator machine execute unit
// Channel  Direction  Word contents
// req      in         func, opcode, addr_a, addr_b, in_value
// rsp      out        acc_value, next_pc, out_valid, out_value, is_halted, status
//
// The data memory read is registered on acceptance, the word executes in S_EXEC and
// the response register loads in S_DONE, which stalls while an earlier response
// is still held for rsp.ready; the next word is accepted back in S_IDLE. Multiply
// and divide wait in S_MULDIV on the bit-serial multiply/divide unit.
// After reset every data memory word is cleared in S_CLEAR with req.ready low.
// A new word is taken while an earlier response still waits on rsp.ready.
// ----------------------------------------------------------------------------
`include "accumulator_machine_execute_top_macros.svh"

module accumulator_machine_execute_top import ame_pkg::*; #(
  parameter int MEM_DEPTH  = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  ame_req_if.sink   req,
  ame_rsp_if.source rsp
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int W  = DATA_WIDTH;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MULDIV,
    S_DONE
  } state_t;

  function automatic logic [AW-1:0] wrap_addr(input logic [ADDR_W-1:0] x);
    logic [23:0] r;
    r = 24'(x);
    for (int k = 3; k >= 0; k--) begin
      if (r >= (24'(MEM_DEPTH) << k)) begin
        r = r - (24'(MEM_DEPTH) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] step_pc(input logic [AW-1:0] p, input logic [1:0] inc);
    logic [AW:0] s;
    s = {1'b0, p} + (AW + 1)'(inc);
    if (s >= (AW + 1)'(MEM_DEPTH)) begin
      s = s - (AW + 1)'(MEM_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_t        state;
  logic [AW-1:0] clr_cnt;
  logic [W-1:0]  acc;
  logic [AW-1:0] pc;
  logic          halt;

  logic          item_func;
  op_t           item_op;
  logic [AW-1:0] item_a;
  logic [AW-1:0] item_b;
  logic [W-1:0]  item_val;

  logic          res_ovalid;
  logic [W-1:0]  res_outv;
  st_t           res_status;

  logic          rsp_valid;
  logic [W-1:0]  rsp_acc;
  logic [AW-1:0] rsp_pc;
  logic          rsp_ovalid;
  logic [W-1:0]  rsp_outv;
  logic          rsp_halt;
  st_t           rsp_status;

  logic          accept;
  logic          live;
  logic [W-1:0]  mem_rd;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic [AW-1:0] pc2;
  logic [AW-1:0] pc3;
  md_cmd_t       md_cmd;
  logic          md_busy;
  logic          md_fin;
  logic [W-1:0]  md_result;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign live      = (state == S_EXEC) && (item_func == FUNC_EXEC) && !halt;
  assign pc2       = step_pc(pc, 2'd2);
  assign pc3       = step_pc(pc, 2'd3);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = item_a;
    wr_data = item_val;
    md_cmd  = '0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else if (state == S_EXEC) begin
      if (item_func == FUNC_WRITE) begin
        wr_en = 1'b1;
      end else if (!halt) begin
        unique case (item_op)
          OP_COPY: begin
            wr_en   = 1'b1;
            wr_addr = item_b;
            wr_data = mem_rd;
          end
          OP_STORE: begin
            wr_en   = 1'b1;
            wr_data = acc;
          end
          OP_INPUT: wr_en = 1'b1;
          OP_MUL: md_cmd = '{start: 1'b1, is_div: 1'b0};
          OP_DIV: md_cmd = '{start: (mem_rd != '0), is_div: 1'b1};
          default: wr_en = 1'b0;
        endcase
      end
    end
  end

  ame_ram #(
    .WIDTH (W),
    .DEPTH (MEM_DEPTH)
  ) u_dmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (wrap_addr(req.addr_a)),
    .rd_data (mem_rd)
  );

  ame_muldiv #(
    .WIDTH (W)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .cmd    (md_cmd),
    .opa    (acc),
    .opb    (mem_rd),
    .busy   (md_busy),
    .fin    (md_fin),
    .result (md_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      acc       <= '0;
      pc        <= '0;
      halt      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_func  <= req.func;
            item_op    <= op_t'(req.opcode);
            item_a     <= wrap_addr(req.addr_a);
            item_b     <= wrap_addr(req.addr_b);
            item_val   <= W'($unsigned(req.in_value));
            res_ovalid <= 1'b0;
            res_outv   <= '0;
            res_status <= ST_OK;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          if (live) begin
            unique case (item_op) inside
              OP_ADD: begin
                acc <= acc + mem_rd;
                pc  <= pc2;
              end
              OP_SUB: begin
                acc <= acc - mem_rd;
                pc  <= pc2;
              end
              OP_MUL: state <= S_MULDIV;
              OP_DIV: begin
                if (mem_rd == '0) begin
                  res_status <= ST_DIV_ZERO;
                  halt       <= 1'b1;
                end else begin
                  state <= S_MULDIV;
                end
              end
              OP_JMP: pc <= item_a;
              OP_JMPN: pc <= acc[W-1] ? item_a : pc2;
              OP_JMPP: pc <= ((acc != '0) && !acc[W-1]) ? item_a : pc2;
              OP_JMPZ: pc <= (acc == '0) ? item_a : pc2;
              OP_COPY: pc <= pc3;
              OP_LOAD: begin
                acc <= mem_rd;
                pc  <= pc2;
              end
              OP_STORE, OP_INPUT: pc <= pc2;
              OP_OUTPUT: begin
                res_ovalid <= 1'b1;
                res_outv   <= mem_rd;
                pc         <= pc2;
              end
              OP_STOP: halt <= 1'b1;
              default: begin
                res_status <= ST_ILLEGAL;
                halt       <= 1'b1;
              end
            endcase
          end
        end
        S_MULDIV: begin
          if (md_fin) begin
            acc   <= md_result;
            pc    <= pc2;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_acc    <= acc;
            rsp_pc     <= pc;
            rsp_ovalid <= res_ovalid;
            rsp_outv   <= res_outv;
            rsp_halt   <= halt;
            rsp_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.acc_value = $signed(VAL_W'(rsp_acc));
  assign rsp.next_pc   = ADDR_W'(rsp_pc);
  assign rsp.out_valid = rsp_ovalid;
  assign rsp.out_value = $signed(VAL_W'(rsp_outv));
  assign rsp.is_halted = rsp_halt;
  assign rsp.status    = rsp_status;

  `AME_ASSERT(a_accept_exec, accept |=> (state == S_EXEC), "accepted word did not execute")
  `AME_ASSERT(a_halted_no_write, (state == S_EXEC && item_func == FUNC_EXEC && halt) |-> !wr_en,
              "halted unit wrote data memory")
  `AME_ASSERT_ALWAYS(a_halt_from_exec, $rose(halt) |-> ($past(state) == S_EXEC),
                     "halt set outside execution")
  `AME_ASSERT(a_muldiv_running, (state == S_MULDIV) |-> (md_busy || md_fin),
              "waiting on an idle multiply/divide unit")

endmodule

// ===== hdl/ame_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ame_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/ame_muldiv.sv =====
// ----------------------------------------------------------------------------
// Iterative multiply/divide unit
// Shift-add multiply and restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
`include "accumulator_machine_execute_top_macros.svh"

module ame_muldiv import ame_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  md_cmd_t          cmd,
  input  logic [WIDTH-1:0] opa,
  input  logic [WIDTH-1:0] opb,
  output logic             busy,
  output logic             fin,
  output logic [WIDTH-1:0] result
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt;
  logic             is_div;
  logic             negq;
  logic [WIDTH-1:0] part;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;

  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic [WIDTH-1:0] mag_a;
  logic [WIDTH-1:0] mag_b;

  always_comb begin
    shifted = {part, quo[WIDTH-1]};
    diff    = {1'b0, shifted} - (WIDTH + 2)'(dvs);
    mag_a   = opa[WIDTH-1] ? (WIDTH'(0) - opa) : opa;
    mag_b   = opb[WIDTH-1] ? (WIDTH'(0) - opb) : opb;
    if (is_div) begin
      result = negq ? (WIDTH'(0) - quo) : quo;
    end else begin
      result = part;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (cmd.start) begin
        busy   <= 1'b1;
        cnt    <= CW'(WIDTH);
        is_div <= cmd.is_div;
        negq   <= opa[WIDTH-1] ^ opb[WIDTH-1];
        part   <= '0;
        if (cmd.is_div) begin
          quo <= mag_a;
          dvs <= mag_b;
        end else begin
          quo <= opb;
          dvs <= opa;
        end
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
        if (is_div) begin
          part <= diff[WIDTH+1] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
          quo  <= {quo[WIDTH-2:0], ~diff[WIDTH+1]};
        end else begin
          if (quo[0]) begin
            part <= part + dvs;
          end
          dvs <= dvs << 1;
          quo <= quo >> 1;
        end
      end
    end
  end

  `AME_ASSERT(a_start_idle, cmd.start |-> !busy, "start while unit busy")
  `AME_ASSERT(a_start_busy, cmd.start |=> busy, "start did not make unit busy")
  `AME_ASSERT(a_fin_after_busy, fin |-> ($past(busy) && !busy), "finish without a run")

endmodule
